// ===== hw/rtl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg
// shared types, codes and the crc-16-ccitt byte step for the frame receiver
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int FRAME_MAX_DEF = 2048;

    // field widths
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 12;
    localparam int MAC_W    = 48;
    localparam int CFG_IDX_W = 2;

    localparam int IN_BITS  = MODE_W + BYTE_W + INDEX_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + LEN_W + BYTE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // input modes
    localparam logic [MODE_W-1:0] MODE_LINE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ADDR_MISS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CRC_BAD    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ       = 3'd6;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE    = 2'd2;

    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'hdb;
    localparam logic [BYTE_W-1:0] END_RST    = 8'hc0;
    localparam logic [15:0]       CRC_INIT   = 16'hffff;
    localparam logic [15:0]       CRC_GOOD   = 16'h0000;
    localparam logic [15:0]       CRC_POLY   = 16'h1021;

    // crc-16-ccitt, msb first, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/efr_store.sv =====
// ----------------------------------------------------------------------------
// efr_store
// frame byte memory, one write and one registered read port
// ----------------------------------------------------------------------------
module efr_store #(
    parameter int DEPTH = efr_pkg::FRAME_MAX_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [efr_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [efr_pkg::BYTE_W-1:0] o_rdata
);
    import efr_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/escaped_frame_receiver_crc_check.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc_check
// byte-stuffed frame deframer with address filter and crc-16-ccitt check
// ----------------------------------------------------------------------------
// path: an accepted word is registered in stage s1, which waits on the memory
//   read, and then in the result register
// throughput: one word per cycle unless the result side holds off; the frame memory has one write and one read
//   port and every word touches at most one of them
// reset (i_rst_n low, synchronous): pipeline empty, no frame open or held,
//   registers back to own_mac 0, escape 0xdb, end 0xc0; memory not cleared
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc_check #(
    parameter int FRAME_MAX = efr_pkg::FRAME_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [efr_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [efr_pkg::MAC_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [efr_pkg::IN_W-1:0]      s_axis_tdata,  // mode[1:0] data_byte[9:2]
                                                         // read_index[20:10]
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [efr_pkg::OUT_W-1:0]     m_axis_tdata   // status[2:0]
                                                         // frame_length[14:3]
                                                         // read_data[22:15]
);
    import efr_pkg::*;

    localparam int AW = $clog2(FRAME_MAX);        // memory address
    localparam int CW = $clog2(FRAME_MAX + 1);    // byte count, holds FRAME_MAX
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    // configuration
    logic [MAC_W-1:0]  r_own_mac;
    logic [BYTE_W-1:0] r_escape;
    logic [BYTE_W-1:0] r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_escape  <= ESCAPE_RST;
            r_end     <= END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_OWN_MAC:     r_own_mac <= i_cfg_wdata;
                CFG_ESCAPE_CODE: r_escape  <= i_cfg_wdata[BYTE_W-1:0];
                CFG_END_CODE:    r_end     <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // frame state
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_crc, n_crc;
    logic          r_esc, n_esc;
    logic          r_rcv, n_rcv;
    logic          r_held, n_held;
    logic          r_aok, n_aok;
    logic          r_mcast, n_mcast;   // bit 0 of stored byte 0

    // pipeline: s1 waits on the memory read, out is the result register
    logic                r_s1_valid;
    logic [STATUS_W-1:0] r_s1_status;
    logic [LEN_W-1:0]    r_s1_len;
    logic                r_s1_rd;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic w_s1_adv;
    logic w_acc;
    assign w_s1_adv      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // input fields
    logic [MODE_W-1:0]  w_mode;
    logic [BYTE_W-1:0]  w_byte;
    logic [INDEX_W-1:0] w_idx;
    assign w_mode = s_axis_tdata[MODE_W-1:0];
    assign w_byte = s_axis_tdata[MODE_W +: BYTE_W];
    assign w_idx  = s_axis_tdata[MODE_W+BYTE_W +: INDEX_W];

    logic [XW-1:0] w_idx_x;
    assign w_idx_x = XW'(w_idx);

    // address byte expected at the current store position, byte 0 is the msb
    logic [BYTE_W-1:0] w_mac_byte;
    always_comb begin
        case (r_count[2:0])
            3'd0:    w_mac_byte = r_own_mac[47:40];
            3'd1:    w_mac_byte = r_own_mac[39:32];
            3'd2:    w_mac_byte = r_own_mac[31:24];
            3'd3:    w_mac_byte = r_own_mac[23:16];
            3'd4:    w_mac_byte = r_own_mac[15:8];
            default: w_mac_byte = r_own_mac[7:0];
        endcase
    end

    // verdict on a closed frame
    logic [STATUS_W-1:0] w_close_st;
    logic                w_addr_hit;
    always_comb begin
        if (r_count == '0) begin
            w_addr_hit = 1'b0;
        end else if (r_mcast) begin
            w_addr_hit = 1'b1;
        end else begin
            w_addr_hit = (r_count >= CW'(6)) && r_aok;
        end
        if (!w_addr_hit) begin
            w_close_st = ST_ADDR_MISS;
        end else if (r_crc != CRC_GOOD) begin
            w_close_st = ST_CRC_BAD;
        end else begin
            w_close_st = ST_ACCEPTED;
        end
    end

    // per-word update
    logic [STATUS_W-1:0] w_status;
    logic [CW-1:0]       w_len;
    logic                w_we;
    logic                w_re;
    logic                w_clear;
    logic                w_match;

    always_comb begin
        n_count  = r_count;
        n_crc    = r_crc;
        n_esc    = r_esc;
        n_rcv    = r_rcv;
        n_held   = r_held;
        n_aok    = r_aok;
        n_mcast  = r_mcast;
        w_status = ST_NONE;
        w_len    = r_count;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_clear  = 1'b0;
        w_match  = (w_byte == w_mac_byte);
        if (w_acc) begin
            unique case (w_mode)
                MODE_LINE: begin
                    n_rcv = 1'b1;
                    if (!r_esc && w_byte == r_escape) begin
                        n_esc = 1'b1;
                    end else if (!r_esc && w_byte == r_end) begin
                        n_rcv = 1'b0;
                        n_esc = 1'b0;
                        if (r_held) begin
                            w_status = ST_BUSY;
                        end else begin
                            w_status = w_close_st;
                            if (w_close_st == ST_ACCEPTED) begin
                                n_held = 1'b1;
                            end else begin
                                w_clear = 1'b1;
                            end
                        end
                    end else begin
                        n_esc = 1'b0;
                        // bytes past capacity are dropped and skip the crc
                        if (!r_held && r_count < CW'(FRAME_MAX)) begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                            n_crc   = crc16_step(r_crc, w_byte);
                            if (r_count == '0) begin
                                n_aok   = w_match;
                                n_mcast = w_byte[0];
                            end else if (r_count < CW'(6)) begin
                                n_aok = r_aok && w_match;
                            end
                        end
                        w_len = n_count;
                    end
                end
                MODE_TIMEOUT: begin
                    if (r_rcv) begin
                        n_rcv = 1'b0;
                        if (r_held) begin
                            n_esc = 1'b0;
                        end else begin
                            w_status = ST_INCOMPLETE;
                            w_clear  = 1'b1;
                        end
                    end
                end
                MODE_READ: begin
                    if (r_held) begin
                        w_status = ST_READ;
                        w_re     = (w_idx_x < XW'(r_count));
                    end
                end
                MODE_RELEASE: begin
                    if (r_held) begin
                        w_status = ST_RELEASED;
                        n_held   = 1'b0;
                        w_clear  = 1'b1;
                    end
                end
                default: ;
            endcase
            if (w_clear) begin
                n_count = '0;
                n_crc   = CRC_INIT;
                n_aok   = 1'b0;
                n_esc   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_esc   <= 1'b0;
            r_rcv   <= 1'b0;
            r_held  <= 1'b0;
            r_aok   <= 1'b0;
            r_mcast <= 1'b0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_esc   <= n_esc;
            r_rcv   <= n_rcv;
            r_held  <= n_held;
            r_aok   <= n_aok;
            r_mcast <= n_mcast;
        end
    end

    // frame memory; writes only while no frame is held, reads only while held
    logic [BYTE_W-1:0] w_rdata;
    logic [LW-1:0]     w_len_x;
    assign w_len_x = LW'(w_len);

    efr_store #(
        .DEPTH (FRAME_MAX),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_byte),
        .i_re    (w_re),
        .i_raddr (w_idx_x[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // stage 1: waits for the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_status <= w_status;
            r_s1_len    <= w_len_x[LEN_W-1:0];
            r_s1_rd     <= w_re;
        end
    end

    // result register; the input stalls only when both stages are full and
    // the result side holds off
    logic [BYTE_W-1:0] w_s1_rdata;
    assign w_s1_rdata = r_s1_rd ? w_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_data <= OUT_W'({w_s1_rdata, r_s1_len, r_s1_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/efr_checker.sv =====
// ----------------------------------------------------------------------------
// efr_checker
// port-level checks on the frame receiver result stream
// ----------------------------------------------------------------------------
module efr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [efr_pkg::OUT_W-1:0] m_axis_tdata
);
    import efr_pkg::*;

    logic [STATUS_W-1:0] w_status;
    logic [LEN_W-1:0]    w_len;
    logic [BYTE_W-1:0]   w_rd;
    assign w_status = m_axis_tdata[STATUS_W-1:0];
    assign w_len    = m_axis_tdata[STATUS_W +: LEN_W];
    assign w_rd     = m_axis_tdata[STATUS_W+LEN_W +: BYTE_W];

    // a stalled word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // read data only on a read result
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status != ST_READ |-> w_rd == '0)
        else $error("read data nonzero outside a read");

    // an accepted frame always holds bytes
    a_acc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == ST_ACCEPTED |-> w_len >= LEN_W'(6) || w_len != '0)
        else $error("accepted frame with no bytes");

    // pipeline empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind escaped_frame_receiver_crc_check efr_checker u_efr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
